// ----- rtl/psen_pkg.sv -----
// Shared widths, codes and controller/datapath handshake types of the siphon enumerator.
package psen_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_PLACES_DEF      = 16;
  localparam int MAX_TRANSITIONS_DEF = 32;
  localparam int MAX_KEPT_DEF        = 256;

  // Fixed field widths of the channels
  localparam int KIND_W     = 2;
  localparam int PLACE_W    = 4;
  localparam int TRANS_W    = 5;
  localparam int WEIGHT_W   = 8;
  localparam int MASK_W     = 16;
  localparam int SIZE_W     = 5;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int PCNT_W     = 5;

  localparam logic [PCNT_W-1:0] PCNT_RST = 5'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_FOUND     = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLACE_COUNT  = 1'b0,
    REG_MINIMAL_ONLY = 1'b1
  } reg_idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr;         // store the sign of one incidence entry
    logic clr;        // clear matrix, cursor and kept list
    logic req_start;  // load the first candidate of a request
    logic scan;       // process one place of the candidate
    logic kstart;     // rewind the kept list walk
    logic kstep;      // read / compare one kept entry
    logic adv;        // move to the next candidate
    logic commit;     // accept candidate as the result
    logic exhaust;    // mark the walk finished
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;       // walk already finished
    logic scan_last;  // scan at place zero
    logic siphon;     // tested candidate is a siphon
    logic min_mode;   // minimal mode selected
    logic khit;       // candidate holds a kept siphon
    logic kend;       // kept list walked without a hit
    logic can_adv;    // another candidate exists
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// ----- rtl/psen_in_if.sv -----
// Input channel: incidence writes, requests and clears.
interface psen_in_if;
  logic                                valid;
  logic                                ready;
  logic [psen_pkg::KIND_W-1:0]         kind;
  logic [psen_pkg::PLACE_W-1:0]        place;
  logic [psen_pkg::TRANS_W-1:0]        transition;
  logic signed [psen_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, kind, place, transition, weight, input ready);
  modport sink   (input valid, kind, place, transition, weight, output ready);
endinterface

// ----- rtl/psen_out_if.sv -----
// Result channel: found siphon, its size and status.
interface psen_out_if;
  logic                          valid;
  logic                          ready;
  logic [psen_pkg::MASK_W-1:0]   siphon_mask;
  logic [psen_pkg::SIZE_W-1:0]   siphon_size;
  logic [psen_pkg::STAT_W-1:0]   status;

  modport source (output valid, siphon_mask, siphon_size, status, input ready);
  modport sink   (input valid, siphon_mask, siphon_size, status, output ready);
endinterface

// ----- rtl/psen_cfg_if.sv -----
// Configuration write channel: register index and data.
interface psen_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psen_pkg::CFG_IDX_W-1:0]    index;
  logic [psen_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/psen_dp.sv -----
// Datapath: sign masks, candidate scan, kept siphon memory and result registers.
module psen_dp #(
  parameter int MAX_PLACES      = psen_pkg::MAX_PLACES_DEF,
  parameter int MAX_TRANSITIONS = psen_pkg::MAX_TRANSITIONS_DEF,
  parameter int MAX_KEPT        = psen_pkg::MAX_KEPT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  psen_pkg::cmd_t                       cmd,
  output psen_pkg::sts_t                       sts,
  input  logic [psen_pkg::PLACE_W-1:0]         in_place,
  input  logic [psen_pkg::TRANS_W-1:0]         in_transition,
  input  logic signed [psen_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                                 cfg_wr,
  input  logic [psen_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psen_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [psen_pkg::MASK_W-1:0]          out_siphon_mask,
  output logic [psen_pkg::SIZE_W-1:0]          out_siphon_size,
  output logic [psen_pkg::STAT_W-1:0]          out_status
);

  localparam int PIW = $clog2(MAX_PLACES);
  localparam int CW  = $clog2(MAX_PLACES + 1);
  localparam int KIW = $clog2(MAX_KEPT);
  localparam int KCW = $clog2(MAX_KEPT + 1);
  localparam int MW  = psen_pkg::MASK_W;
  localparam int SW  = psen_pkg::SIZE_W;

  // configuration
  logic [psen_pkg::PCNT_W-1:0] pcnt_r;
  logic                        minm_r;
  logic [CW-1:0]               n_c;

  // sign masks per place
  logic [MAX_TRANSITIONS-1:0] prod_r [MAX_PLACES];
  logic [MAX_TRANSITIONS-1:0] cons_r [MAX_PLACES];
  logic [MAX_TRANSITIONS-1:0] tsel;
  logic                       wr_ok;
  logic                       w_pos;
  logic                       w_neg;

  // walk state
  logic [MAX_PLACES-1:0] cur_r;
  logic [CW-1:0]         csize_r;
  logic                  done_r;
  logic [KCW-1:0]        kcnt_r;
  logic                  keep_room;

  // candidate scan
  logic [MAX_PLACES-1:0]      cand_r;
  logic [CW-1:0]              k_r;
  logic                       test_r;
  logic [PIW-1:0]             pidx_r;
  logic [CW-1:0]              acnt_r;
  logic [MAX_TRANSITIONS-1:0] pre_r;
  logic [MAX_TRANSITIONS-1:0] post_r;
  logic                       fnd_r;
  logic [PIW-1:0]             fpos_r;
  logic [CW-1:0]              fa_r;
  logic [CW:0]                reach;
  logic                       cbit;
  logic [MAX_PLACES-1:0]      succ;
  logic [MAX_PLACES-1:0]      upmask;

  // kept siphons
  logic [MAX_PLACES-1:0] kept_mem [MAX_KEPT];
  logic [MAX_PLACES-1:0] kdat_r;
  logic [KCW-1:0]        kidx_r;
  logic                  kvld_r;

  // result and output register
  logic [MW-1:0]                 res_mask_r;
  logic [SW-1:0]                 res_size_r;
  logic [psen_pkg::STAT_W-1:0]   res_stat_r;
  logic                          out_vld_r;
  logic [MW-1:0]                 out_mask_r;
  logic [SW-1:0]                 out_size_r;
  logic [psen_pkg::STAT_W-1:0]   out_stat_r;
  logic [MAX_PLACES+MW-1:0]      cand_pad;
  logic [CW+SW-1:0]              k_pad;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= psen_pkg::PCNT_RST;
      minm_r <= 1'b0;
    end else if (cfg_wr) begin
      case (psen_pkg::reg_idx_t'(cfg_index))
        psen_pkg::REG_PLACE_COUNT:  pcnt_r <= cfg_data;
        psen_pkg::REG_MINIMAL_ONLY: minm_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp place count to 1..MAX_PLACES
  always_comb begin
    if (pcnt_r == '0) begin
      n_c = CW'(1);
    end else if (int'(pcnt_r) > MAX_PLACES) begin
      n_c = CW'(MAX_PLACES);
    end else begin
      n_c = CW'(pcnt_r);
    end
  end

  // decode the entry write
  always_comb begin
    for (int t = 0; t < MAX_TRANSITIONS; t++) begin
      tsel[t] = (t == int'(in_transition));
    end
    wr_ok = (int'(in_place) < MAX_PLACES) && (int'(in_transition) < MAX_TRANSITIONS);
    w_neg = in_weight[psen_pkg::WEIGHT_W-1];
    w_pos = !w_neg && (in_weight != '0);
  end

  // sign masks: each row updates only when its place is addressed
  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_PLACES; p++) begin
      if (!rst_n || cmd.clr) begin
        prod_r[p] <= '0;
        cons_r[p] <= '0;
      end else if (cmd.wr && wr_ok && (p == int'(in_place))) begin
        prod_r[p] <= (prod_r[p] & ~tsel) | (w_pos ? tsel : '0);
        cons_r[p] <= (cons_r[p] & ~tsel) | (w_neg ? tsel : '0);
      end
    end
  end

  // cursor, kept count and exhaustion flag
  assign keep_room = int'(kcnt_r) < MAX_KEPT;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      cur_r   <= '0;
      csize_r <= CW'(1);
      done_r  <= 1'b0;
      kcnt_r  <= '0;
    end else begin
      if (cmd.commit) begin
        cur_r   <= cand_r;
        csize_r <= k_r;
        if (minm_r && keep_room) begin
          kcnt_r <= kcnt_r + 1'b1;
        end
      end
      if (cmd.exhaust) begin
        done_r <= 1'b1;
      end
    end
  end

  // one scan step: room test for the highest movable place
  assign cbit  = cand_r[pidx_r];
  assign reach = (CW+1)'(pidx_r) + (CW+1)'(acnt_r) + (CW+1)'(1);

  // successor of the same size and first subset of the next size
  always_comb begin
    for (int i = 0; i < MAX_PLACES; i++) begin
      if (i < int'(fpos_r)) begin
        succ[i] = cand_r[i];
      end else begin
        succ[i] = (i > int'(fpos_r)) && (i <= int'(fpos_r) + int'(fa_r) + 1);
      end
      upmask[i] = i < int'(k_r) + 1;
    end
  end

  // candidate load and place-by-place scan
  always_ff @(posedge clk) begin
    if (cmd.req_start || cmd.adv) begin
      pidx_r <= PIW'(MAX_PLACES - 1);
      acnt_r <= '0;
      pre_r  <= '0;
      post_r <= '0;
      fnd_r  <= 1'b0;
      if (cmd.req_start) begin
        if (cur_r == '0) begin
          cand_r <= MAX_PLACES'(1);
          k_r    <= CW'(1);
          test_r <= 1'b1;
        end else begin
          cand_r <= cur_r;
          k_r    <= csize_r;
          test_r <= 1'b0;
        end
      end else begin
        test_r <= 1'b1;
        if (fnd_r) begin
          cand_r <= succ;
        end else begin
          cand_r <= upmask;
          k_r    <= k_r + 1'b1;
        end
      end
    end else if (cmd.scan) begin
      pidx_r <= pidx_r - 1'b1;
      if (cbit) begin
        pre_r  <= pre_r | prod_r[pidx_r];
        post_r <= post_r | cons_r[pidx_r];
        acnt_r <= acnt_r + 1'b1;
        if (!fnd_r && (reach < (CW+1)'(n_c))) begin
          fnd_r  <= 1'b1;
          fpos_r <= pidx_r;
          fa_r   <= acnt_r;
        end
      end
    end
  end

  // kept siphon memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && minm_r && keep_room) begin
      kept_mem[kcnt_r[KIW-1:0]] <= cand_r;
    end
    kdat_r <= kept_mem[kidx_r[KIW-1:0]];
  end

  // walk the kept list one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kidx_r <= '0;
      kvld_r <= 1'b0;
    end else if (cmd.kstart) begin
      kidx_r <= '0;
      kvld_r <= 1'b0;
    end else if (cmd.kstep) begin
      if (kidx_r < kcnt_r) begin
        kidx_r <= kidx_r + 1'b1;
        kvld_r <= 1'b1;
      end else begin
        kvld_r <= 1'b0;
      end
    end
  end

  // result registers
  assign cand_pad = {{MW{1'b0}}, cand_r};
  assign k_pad    = {{SW{1'b0}}, k_r};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_mask_r <= cand_pad[MW-1:0];
      res_size_r <= k_pad[SW-1:0];
      res_stat_r <= (minm_r && !keep_room) ? psen_pkg::STAT_OVERFLOW : psen_pkg::STAT_FOUND;
    end else if (cmd.exhaust) begin
      res_mask_r <= '0;
      res_size_r <= '0;
      res_stat_r <= psen_pkg::STAT_EXHAUSTED;
    end
  end

  // output register: hold until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mask_r <= res_mask_r;
      out_size_r <= res_size_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_siphon_mask = out_mask_r;
  assign out_siphon_size = out_size_r;
  assign out_status      = out_stat_r;

  // status to the controller
  always_comb begin
    sts.done      = done_r;
    sts.scan_last = (pidx_r == '0);
    sts.siphon    = test_r && ((pre_r & ~post_r) == '0);
    sts.min_mode  = minm_r;
    sts.khit      = kvld_r && ((cand_r & kdat_r) == kdat_r);
    sts.kend      = !kvld_r && (kidx_r == kcnt_r);
    sts.can_adv   = fnd_r || (int'(k_r) + 1 <= int'(n_c));
    sts.out_free  = !out_vld_r || out_ready;
  end

  // a kept siphon adds exactly one entry
  a_kept_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && minm_r && keep_room |=> kcnt_r == $past(kcnt_r) + 1'b1)
    else $error("kept count did not advance on a kept siphon");

  // a new candidate is never the empty set
  a_cand_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |=> cand_r != '0)
    else $error("advance produced an empty candidate");

endmodule

// ----- rtl/psen_ctrl.sv -----
// Controller: sequences writes, candidate scans, kept checks and result hand-off.
module psen_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [psen_pkg::KIND_W-1:0]   in_kind,
  output logic                          in_ready,
  output psen_pkg::cmd_t                cmd,
  input  psen_pkg::sts_t                sts
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_KCHK   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      // take one item; writes and clears finish here
      ST_IDLE: begin
        if (in_valid) begin
          case (psen_pkg::kind_t'(in_kind))
            psen_pkg::KIND_WRITE: cmd.wr  = 1'b1;
            psen_pkg::KIND_CLEAR: cmd.clr = 1'b1;
            psen_pkg::KIND_REQUEST: begin
              if (sts.done) begin
                cmd.exhaust = 1'b1;
                state_nxt   = ST_EMIT;
              end else begin
                cmd.req_start = 1'b1;
                state_nxt     = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      // step through the places of the candidate
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      // keep, check against the kept list, advance, or mark the walk finished
      ST_DECIDE: begin
        if (sts.siphon) begin
          if (sts.min_mode) begin
            cmd.kstart = 1'b1;
            state_nxt  = ST_KCHK;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = ST_EMIT;
          end
        end else if (sts.can_adv) begin
          cmd.adv   = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          cmd.exhaust = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      // drop candidates that hold a kept siphon, commit one once the list is walked without a hit
      ST_KCHK: begin
        cmd.kstep = 1'b1;
        if (sts.khit) begin
          if (sts.can_adv) begin
            cmd.adv   = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.exhaust = 1'b1;
            state_nxt   = ST_EMIT;
          end
        end else if (sts.kend) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      // wait for room in the output register
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the end of a scan always leads to a decision
  a_scan_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && sts.scan_last |=> state_r == ST_DECIDE)
    else $error("scan end did not reach decide");

  // at most one way of leaving a candidate per cycle
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.adv, cmd.commit, cmd.exhaust, cmd.req_start}))
    else $error("conflicting candidate commands");

  // a request on a finished walk goes straight to the emit state
  a_done_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == psen_pkg::KIND_REQUEST && sts.done
    |=> state_r == ST_EMIT)
    else $error("finished walk did not answer directly");

endmodule

// ----- rtl/petri_siphon_enumerator.sv -----
// Top level of the Petri net siphon enumerator.
//
//   channel  | dir | fields                                  | transfer when
//   ---------+-----+-----------------------------------------+-------------------
//   in_ch    | in  | kind, place, transition, weight         | valid && ready
//   out_ch   | out | siphon_mask, siphon_size, status        | valid && ready
//   cfg_ch   | in  | index (0 place_count, 1 minimal_only)   | valid (ready = 1)
//
// Writes, clears and unused kinds finish in the idle state; a request on a finished walk goes
// straight to the emit state. Other requests are accepted, then scan every place of each
// candidate (cursor rescan included), walk the kept list for each siphon checked in minimal
// mode, and load the output register once it has room.
// Reset is synchronous and clears masks, cursor and kept count at once, no clearing pass.
// Input is taken while a result waits; a request that finishes meanwhile holds until it drains.
module petri_siphon_enumerator #(
  parameter int MAX_PLACES      = psen_pkg::MAX_PLACES_DEF,
  parameter int MAX_TRANSITIONS = psen_pkg::MAX_TRANSITIONS_DEF,
  parameter int MAX_KEPT        = psen_pkg::MAX_KEPT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  psen_in_if.sink    in_ch,
  psen_out_if.source out_ch,
  psen_cfg_if.sink   cfg_ch
);

  psen_pkg::cmd_t cmd;
  psen_pkg::sts_t sts;

  // configuration is always taken
  assign cfg_ch.ready = 1'b1;

  psen_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  psen_dp #(
    .MAX_PLACES      (MAX_PLACES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS),
    .MAX_KEPT        (MAX_KEPT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_place        (in_ch.place),
    .in_transition   (in_ch.transition),
    .in_weight       (in_ch.weight),
    .cfg_wr          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_siphon_mask (out_ch.siphon_mask),
    .out_siphon_size (out_ch.siphon_size),
    .out_status      (out_ch.status)
  );

endmodule

// ----- dv/psen_checker.sv -----
// Siphon enumerator scoreboard: predicts each request result from observed transfers.
module psen_checker (
  input  logic clk,
  input  logic rst_n,
  psen_in_if   in_mon,
  psen_out_if  out_mon,
  psen_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import psen_pkg::*;

  localparam int NPLACE = MAX_PLACES_DEF;
  localparam int NTRANS = MAX_TRANSITIONS_DEF;
  localparam int NKEPT  = MAX_KEPT_DEF;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [SIZE_W-1:0] size;
    stat_t             status;
  } siphon_res_t;

  // Sign pattern of the incidence matrix, one row per place
  logic [NTRANS-1:0] prod_sign [NPLACE];
  logic [NTRANS-1:0] cons_sign [NPLACE];

  // Walk position, kept minimal siphons and register copies
  logic [MASK_W-1:0] walk_pos;
  logic [MASK_W-1:0] kept_set [NKEPT];
  int                kept_n;
  bit                walk_over;
  logic [PCNT_W-1:0] pcount_reg;
  bit                min_mode;
  int                mismatches;

  siphon_res_t siphon_due[$];

  function automatic int ones(logic [MASK_W-1:0] v);
    int c;
    c = 0;
    for (int i = 0; i < MASK_W; i++) c += int'(v[i]);
    return c;
  endfunction

  // Lexicographic successor among subsets of equal size within n places
  function automatic bit next_combo(input logic [MASK_W-1:0] cur, input int n,
                                    output logic [MASK_W-1:0] nxt);
    int pos [MASK_W];
    int cnt;
    int j;
    cnt = 0;
    nxt = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (cur[i]) begin
        pos[cnt] = i;
        cnt++;
      end
    end
    j = cnt - 1;
    while (j >= 0 && pos[j] >= n - cnt + j) j--;
    if (j < 0) return 1'b0;
    pos[j]++;
    for (int i = j + 1; i < cnt; i++) pos[i] = pos[i-1] + 1;
    for (int i = 0; i < cnt; i++) nxt[pos[i]] = 1'b1;
    return 1'b1;
  endfunction

  // Step to the next candidate, growing the size when a size runs out
  function automatic bit step_walk(inout logic [MASK_W-1:0] cand, inout int k, input int n);
    logic [MASK_W-1:0] nxt;
    if (next_combo(cand, n, nxt)) begin
      cand = nxt;
      return 1'b1;
    end
    k++;
    if (k > n) return 1'b0;
    cand = (16'd1 << k) - 16'd1;
    return 1'b1;
  endfunction

  function automatic bit is_siphon(logic [MASK_W-1:0] s);
    logic [NTRANS-1:0] pre;
    logic [NTRANS-1:0] post;
    pre  = '0;
    post = '0;
    for (int p = 0; p < NPLACE; p++) begin
      if (s[p]) begin
        pre  |= prod_sign[p];
        post |= cons_sign[p];
      end
    end
    return (pre & ~post) == '0;
  endfunction

  function automatic bit holds_kept(logic [MASK_W-1:0] s);
    for (int i = 0; i < kept_n && i < NKEPT; i++)
      if ((s & kept_set[i]) == kept_set[i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic clear_net();
    for (int p = 0; p < NPLACE; p++) begin
      prod_sign[p] = '0;
      cons_sign[p] = '0;
    end
    walk_pos  = '0;
    kept_n    = 0;
    walk_over = 1'b0;
  endtask

  // Resume the walk from the cursor and return the next siphon or exhaustion
  task automatic find_siphon(output siphon_res_t r);
    logic [MASK_W-1:0] cand;
    int k;
    int n;
    bit ok;
    r.mask   = '0;
    r.size   = '0;
    r.status = STAT_EXHAUSTED;
    if (walk_over) return;
    n = int'(pcount_reg);
    if (n < 1) n = 1;
    if (n > NPLACE) n = NPLACE;
    if (walk_pos == '0) begin
      cand = 16'd1;
      k    = 1;
      ok   = 1'b1;
    end else begin
      cand = walk_pos;
      k    = ones(cand);
      ok   = step_walk(cand, k, n);
    end
    while (ok) begin
      if (!(min_mode && holds_kept(cand)) && is_siphon(cand)) begin
        r.status = STAT_FOUND;
        if (min_mode) begin
          if (kept_n < NKEPT) begin
            kept_set[kept_n] = cand;
            kept_n++;
          end else begin
            r.status = STAT_OVERFLOW;
          end
        end
        walk_pos = cand;
        r.mask   = cand;
        r.size   = SIZE_W'(k);
        return;
      end
      ok = step_walk(cand, k, n);
    end
    walk_over = 1'b1;
  endtask

  always @(posedge clk) begin
    siphon_res_t want;
    siphon_res_t got;
    if (!rst_n) begin
      clear_net();
      pcount_reg = PCNT_RST;
      min_mode   = 1'b0;
      mismatches = 0;
      siphon_due.delete();
    end else begin
      // Track register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_PLACE_COUNT) pcount_reg = cfg_mon.data[PCNT_W-1:0];
        else min_mode = cfg_mon.data[0];
      end

      // Compare each result transfer with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (siphon_due.size() == 0) begin
          $error("result with no request waiting: siphon_mask %h", out_mon.siphon_mask);
          mismatches++;
        end else begin
          want = siphon_due.pop_front();
          if (out_mon.siphon_mask !== want.mask) begin
            $error("siphon_mask: expected %h, actual %h", want.mask, out_mon.siphon_mask);
            mismatches++;
          end
          if (out_mon.siphon_size !== want.size) begin
            $error("siphon_size: expected %0d, actual %0d", want.size, out_mon.siphon_size);
            mismatches++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_mon.status);
            mismatches++;
          end
        end
      end

      // Apply each input transfer to the predicted state
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.kind)
          KIND_WRITE: begin
            if (int'(in_mon.place) < NPLACE && int'(in_mon.transition) < NTRANS) begin
              prod_sign[in_mon.place][in_mon.transition] = 1'b0;
              cons_sign[in_mon.place][in_mon.transition] = 1'b0;
              if (in_mon.weight < 0) cons_sign[in_mon.place][in_mon.transition] = 1'b1;
              else if (in_mon.weight != 0) prod_sign[in_mon.place][in_mon.transition] = 1'b1;
            end
          end
          KIND_REQUEST: begin
            find_siphon(got);
            siphon_due.insert(siphon_due.size(), got);
          end
          KIND_CLEAR: clear_net();
          default: ;
        endcase
      end
    end
    pending    <= siphon_due.size();
    fail_count <= mismatches;
  end

endmodule

// ----- dv/petri_siphon_enumerator_test.sv -----
// Testbench top: drives incidence writes, requests, clears and register writes.
module petri_siphon_enumerator_test;
  import psen_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int PHASE_ITEMS    = 50;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  psen_in_if  in_if ();
  psen_out_if out_if ();
  psen_cfg_if cfg_if ();

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int item_count     = 0;
  int cur_places     = 4;
  int random_end;
  int roll;

  petri_siphon_enumerator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  psen_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the transfer
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PLACE_W-1:0] place,
                           input logic [TRANS_W-1:0] trans,
                           input logic [WEIGHT_W-1:0] weight);
    case ((item_count / PHASE_ITEMS) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_if.valid      = 1'b1;
    in_if.kind       = kind;
    in_if.place      = place;
    in_if.transition = trans;
    in_if.weight     = weight;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    in_if.valid = 1'b0;
    item_count++;
  endtask

  task automatic write_entry(input int place, input int trans, input logic [WEIGHT_W-1:0] w);
    send_item(KIND_WRITE, PLACE_W'(place), TRANS_W'(trans), w);
  endtask

  task automatic request_next();
    send_item(KIND_REQUEST, PLACE_W'($urandom), TRANS_W'($urandom), WEIGHT_W'($urandom));
  endtask

  task automatic clear_net();
    send_item(KIND_CLEAR, PLACE_W'($urandom), TRANS_W'($urandom), WEIGHT_W'($urandom));
  endtask

  // Wait for every result, then let the block drain any write or clear
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    settle();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    if (idx == REG_PLACE_COUNT) begin
      cur_places = value;
      if (cur_places < 1) cur_places = 1;
      if (cur_places > MAX_PLACES_DEF) cur_places = MAX_PLACES_DEF;
    end
  endtask

  function automatic logic [WEIGHT_W-1:0] pos_weight();
    return WEIGHT_W'($urandom_range(1, 127));
  endfunction

  function automatic logic [WEIGHT_W-1:0] neg_weight();
    return WEIGHT_W'(256 - $urandom_range(1, 128));
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    if ($urandom_range(99) < 20) return '0;
    return WEIGHT_W'($urandom);
  endfunction

  // Mostly rows inside the net, now and then any row
  function automatic int rand_place();
    if ($urandom_range(9) == 0) return $urandom_range(15);
    return $urandom_range(cur_places - 1);
  endfunction

  function automatic int rand_trans();
    if ($urandom_range(99) < 70) return $urandom_range(7);
    return $urandom_range(31);
  endfunction

  task automatic rand_write();
    write_entry(rand_place(), rand_trans(), rand_weight());
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_WRITE;
    in_if.place      = '0;
    in_if.transition = '0;
    in_if.weight     = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_PLACE_COUNT;
    cfg_if.data      = '0;

    // Hold reset, then release away from the clock edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: weight extremes, zero weight, unused kind, mode and count changes
    write_entry(0, 0, 8'h7F);
    write_entry(1, 0, 8'h80);
    write_entry(15, 31, 8'h01);
    write_entry(2, 31, 8'hFF);
    write_entry(3, 17, 8'h05);
    write_entry(3, 17, 8'h00);
    send_item(KIND_UNUSED, 4'hF, 5'h1F, 8'h80);
    repeat (3) request_next();
    write_reg(REG_MINIMAL_ONLY, 1);
    repeat (2) request_next();
    // Shrink the net below the cursor size: the walk runs out
    write_reg(REG_PLACE_COUNT, 0);
    repeat (2) request_next();
    clear_net();
    write_reg(REG_MINIMAL_ONLY, 0);
    write_reg(REG_PLACE_COUNT, 31);
    repeat (2) request_next();

    // Sweep the remaining singletons of the widest net on an empty matrix, then the first pair
    write_reg(REG_PLACE_COUNT, 16);
    repeat (15) request_next();
    clear_net();

    // Random nets, mostly small, with matrix and register changes mid-walk
    random_end = item_count + RANDOM_ITEMS;
    while (item_count < random_end) begin
      roll = $urandom_range(99);
      if (roll < 5) write_reg(REG_PLACE_COUNT, 0);
      else if (roll < 20) write_reg(REG_PLACE_COUNT, $urandom_range(7, 8));
      else write_reg(REG_PLACE_COUNT, $urandom_range(1, 6));
      write_reg(REG_MINIMAL_ONLY, $urandom_range(1));
      if ($urandom_range(99) < 85) clear_net();
      repeat ($urandom_range(2 * cur_places + 4)) rand_write();
      repeat ($urandom_range(1, 12)) begin
        roll = $urandom_range(99);
        if (roll < 12) rand_write();
        else if (roll < 16) send_item(KIND_UNUSED, PLACE_W'($urandom), TRANS_W'($urandom),
                                      WEIGHT_W'($urandom));
        else if (roll < 18) clear_net();
        else if (roll < 21) write_reg(REG_MINIMAL_ONLY, $urandom_range(1));
        else if (roll < 24) write_reg(REG_PLACE_COUNT, $urandom_range(1, 8));
        else request_next();
      end
    end

    // Overflow: a net whose first siphon is places 0..5, then empty it in minimal mode
    clear_net();
    write_reg(REG_MINIMAL_ONLY, 0);
    write_reg(REG_PLACE_COUNT, 12);
    for (int p = 0; p < 6; p++) begin
      write_entry(p, p, pos_weight());
      write_entry((p + 1) % 6, p, neg_weight());
    end
    for (int q = 6; q < 12; q++) write_entry(q, 16, pos_weight());
    write_entry(0, 16, neg_weight());
    request_next();
    for (int p = 0; p < 6; p++) begin
      write_entry(p, p, 8'h00);
      write_entry((p + 1) % 6, p, 8'h00);
    end
    for (int q = 6; q < 12; q++) write_entry(q, 16, 8'h00);
    write_entry(0, 16, 8'h00);
    write_reg(REG_MINIMAL_ONLY, 1);
    repeat (MAX_KEPT_DEF + 6) request_next();

    // Drain the last results and give the verdict
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
